/* src/pcfe_pkg.sv */
`timescale 1ns / 1ps
// Package for the proximity card frame encoder: format codes, frame constants
// and the per-format tables. No dependencies.
package pcfe_pkg;

    typedef logic [1:0] fmt_t;

    localparam fmt_t FMT_26 = 2'd0;
    localparam fmt_t FMT_34 = 2'd1;
    localparam fmt_t FMT_37 = 2'd2;
    localparam fmt_t FMT_50 = 2'd3;

    localparam int CODE_W    = 48;
    localparam int PAYLOAD_W = 66;
    localparam int FRAME_W   = 96;
    localparam int GROUPS    = PAYLOAD_W / 3;

    localparam logic [7:0] PREAMBLE = 8'h01;

    // Length value written into the frame
    function automatic logic [7:0] fmt_length(input fmt_t sel);
        logic [7:0] len;
        begin
            unique case (sel)
                FMT_34:  len = 8'd34;
                FMT_37:  len = 8'd37;
                FMT_50:  len = 8'd50;
                default: len = 8'd26;
            endcase
            return len;
        end
    endfunction

    // Code bits covered by the leading even parity (code bit 0 at bit 47)
    function automatic logic [CODE_W-1:0] lo_mask(input fmt_t sel);
        logic [CODE_W-1:0] m;
        begin
            unique case (sel)
                FMT_34:  m = 48'hFFFF_0000_0000;
                FMT_37:  m = 48'hFFFE_0000_0000;
                FMT_50:  m = 48'hFFFF_FF00_0000;
                default: m = 48'hFFF0_0000_0000;
            endcase
            return m;
        end
    endfunction

    // Code bits covered by the trailing odd parity
    function automatic logic [CODE_W-1:0] hi_mask(input fmt_t sel);
        logic [CODE_W-1:0] m;
        begin
            unique case (sel)
                FMT_34:  m = 48'h0000_FFFF_0000;
                FMT_37:  m = 48'h0001_FFFC_0000;
                FMT_50:  m = 48'h0000_00FF_FFFF;
                default: m = 48'h000F_FF00_0000;
            endcase
            return m;
        end
    endfunction

endpackage

/* src/prox_card_frame_encoder.sv */
`timescale 1ns / 1ps
// Proximity card frame encoder, top level and only module.
// Depends on pcfe_pkg for format codes, masks and frame constants.

// Takes one card word (format length, facility code, card number) per clock
// while card_stall is low and returns one 96-bit frame word from the output
// register for each, one word per cycle while frame_stall is low. The three
// register stages are: format decode and masking, payload parity and
// assembly, group parity and frame packing (the last stage is the output
// register). A stalled output fills the empty stages before card_stall rises;
// nothing is dropped or doubled. Unknown length codes encode as format 26.
module prox_card_frame_encoder
    import pcfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        card_valid,
    output logic        card_stall,
    input  logic [7:0]  format_length,
    input  logic [31:0] facility_code,
    input  logic [31:0] card_number,

    output logic        frame_valid,
    input  logic        frame_stall,
    output logic [31:0] frame_head,
    output logic [63:0] frame_tail,
    output logic [1:0]  format_used,
    output logic        was_truncated
);

    // Stage registers
    logic                 s1_valid_reg;
    fmt_t                 s1_sel_reg;
    logic                 s1_trunc_reg;
    logic [CODE_W-1:0]    s1_code_reg;

    logic                 s2_valid_reg;
    fmt_t                 s2_sel_reg;
    logic                 s2_trunc_reg;
    logic [PAYLOAD_W-1:0] s2_pay_reg;

    logic                 s3_valid_reg;
    fmt_t                 s3_sel_reg;
    logic                 s3_trunc_reg;
    logic [FRAME_W-1:0]   s3_frame_reg;

    // Next values
    fmt_t                 s1_sel_next;
    logic                 s1_trunc_next;
    logic [CODE_W-1:0]    s1_code_next;
    logic [PAYLOAD_W-1:0] s2_pay_next;
    logic [FRAME_W-1:0]   s3_frame_next;

    logic en1, en2, en3;
    logic par_even, par_odd;

    // Advance a stage when it is empty or its word moves on
    assign en3 = !s3_valid_reg || !frame_stall;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;
    assign card_stall = !en1;

    // Stage 1: decode format, mask codes, left-align code bits
    always_comb
    begin
        unique case (format_length)
            8'd34:
            begin
                s1_sel_next   = FMT_34;
                s1_code_next  = {facility_code[7:0], card_number[23:0], 16'd0};
                s1_trunc_next = (|facility_code[31:8]) || (|card_number[31:24]);
            end
            8'd37:
            begin
                s1_sel_next   = FMT_37;
                s1_code_next  = {facility_code[12:0], card_number[17:0], 17'd0};
                s1_trunc_next = (|facility_code[31:13]) || (|card_number[31:18]);
            end
            8'd50:
            begin
                s1_sel_next   = FMT_50;
                s1_code_next  = {facility_code[15:0], card_number};
                s1_trunc_next = |facility_code[31:16];
            end
            default:
            begin
                s1_sel_next   = FMT_26;
                s1_code_next  = {facility_code[7:0], card_number[15:0], 24'd0};
                s1_trunc_next = (|facility_code[31:8]) || (|card_number[31:16]);
            end
        endcase
    end

    // Stage 2: half parities, place length, parities and code bits
    always_comb
    begin
        par_even    = ^(s1_code_reg & lo_mask(s1_sel_reg));
        par_odd     = ~^(s1_code_reg & hi_mask(s1_sel_reg));
        s2_pay_next = {fmt_length(s1_sel_reg), par_even, s1_code_reg, 9'd0};
        // Odd parity sits right after the last code bit
        unique case (s1_sel_reg)
            FMT_34:  s2_pay_next[24] = par_odd;
            FMT_37:  s2_pay_next[25] = par_odd;
            FMT_50:  s2_pay_next[8]  = par_odd;
            default: s2_pay_next[32] = par_odd;
        endcase
    end

    // Stage 3: odd parity after every three payload bits, prepend preamble
    always_comb
    begin
        s3_frame_next = '0;
        s3_frame_next[FRAME_W-1 -: 8] = PREAMBLE;
        for (int g = 0; g < GROUPS; g++)
        begin
            s3_frame_next[FRAME_W-9-4*g -: 3] = s2_pay_reg[PAYLOAD_W-1-3*g -: 3];
            s3_frame_next[FRAME_W-12-4*g]     = ~^s2_pay_reg[PAYLOAD_W-1-3*g -: 3];
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= card_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Payload registers: load only on a live word, hold otherwise
    always_ff @(posedge clk)
    begin
        if (en1 && card_valid)
        begin
            s1_sel_reg   <= s1_sel_next;
            s1_trunc_reg <= s1_trunc_next;
            s1_code_reg  <= s1_code_next;
        end
        if (en2 && s1_valid_reg)
        begin
            s2_sel_reg   <= s1_sel_reg;
            s2_trunc_reg <= s1_trunc_reg;
            s2_pay_reg   <= s2_pay_next;
        end
        if (en3 && s2_valid_reg)
        begin
            s3_sel_reg   <= s2_sel_reg;
            s3_trunc_reg <= s2_trunc_reg;
            s3_frame_reg <= s3_frame_next;
        end
    end

    assign frame_valid   = s3_valid_reg;
    assign frame_head    = s3_frame_reg[FRAME_W-1 -: 32];
    assign frame_tail    = s3_frame_reg[63:0];
    assign format_used   = s3_sel_reg;
    assign was_truncated = s3_trunc_reg;

    // Every output group must carry odd parity
    logic groups_odd;
    always_comb
    begin
        groups_odd = 1'b1;
        for (int g = 0; g < GROUPS; g++)
        begin
            groups_odd = groups_odd && (^s3_frame_reg[FRAME_W-9-4*g -: 4]);
        end
    end

    // Checks
    a_preamble: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid |-> (frame_head[31:24] == PREAMBLE))
        else $error("frame preamble corrupted");

    a_group_parity: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid |-> groups_odd)
        else $error("frame group parity wrong");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        card_stall |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg && frame_stall))
        else $error("input stalled with room in pipeline");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !en2) |=> (s1_valid_reg && $stable(s1_code_reg)))
        else $error("stage one word lost under stall");

endmodule
